/* design/assert_macros.svh */
// assertion macros shared by the bitmap range engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define BRNG_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define BRNG_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/brng_pkg.sv */
// package for the bitmap range engine: constants, codes, microcode and helpers
package brng_pkg;

   localparam int DEFAULT_BIT_CAPACITY = 1024;
   localparam int WORD_BITS            = 64;
   localparam int WORD_SHIFT           = 6;
   localparam int WORD_BYTES           = WORD_BITS / 8;
   localparam int POS_W                = 11;
   localparam int FUNC_W               = 3;
   localparam int INDEX_W              = 10;
   localparam int DEFAULT_WORDS        = (DEFAULT_BIT_CAPACITY + WORD_BITS - 1) / WORD_BITS;
   localparam int DEFAULT_ADDR_W       = (DEFAULT_WORDS > 1) ? $clog2(DEFAULT_WORDS) : 1;

   localparam logic [POS_W-1:0] BITS_IN_USE_RESET = POS_W'(1024);

   // command codes
   localparam logic [FUNC_W-1:0] FUNC_PUT    = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_GET    = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_SET    = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_INVERT = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_COUNT  = 3'd5;

   // how a walked word is rewritten
   typedef enum logic [1:0] {
      WK_NONE,
      WK_OR,
      WK_ANDN,
      WK_XOR
   } wr_kind_type;

   // microprogram steps
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_WALK,
      ST_SUM,
      ST_DONE
   } step_type;

   // jump conditions
   typedef enum logic [2:0] {
      JC_ALWAYS,
      JC_CLEAR_END,
      JC_ACCEPT,
      JC_HAS_WORK,
      JC_WALK_END,
      JC_RSP_FREE
   } cond_type;

   typedef struct packed {
      logic     req_ready;
      logic     clr_wr;
      logic     walk;
      logic     rsp_load;
      cond_type cond;
      step_type target_t;
      step_type target_f;
   } uword_type;

   typedef struct packed {
      logic accept;
      logic has_work;
      logic walk_end;
      logic clear_end;
      logic rsp_free;
   } seq_status_type;

   // control store
   function automatic uword_type brng_rom(input step_type step);
      uword_type uw;
      uw = '{req_ready: 1'b0, clr_wr: 1'b0, walk: 1'b0, rsp_load: 1'b0,
             cond: JC_ALWAYS, target_t: ST_IDLE, target_f: ST_IDLE};
      unique case (step)
         ST_CLEAR: begin
            uw.clr_wr   = 1'b1;
            uw.cond     = JC_CLEAR_END;
            uw.target_t = ST_IDLE;
            uw.target_f = ST_CLEAR;
         end
         ST_IDLE: begin
            uw.req_ready = 1'b1;
            uw.cond      = JC_ACCEPT;
            uw.target_t  = ST_CHECK;
            uw.target_f  = ST_IDLE;
         end
         ST_CHECK: begin
            uw.cond     = JC_HAS_WORK;
            uw.target_t = ST_WALK;
            uw.target_f = ST_SUM;
         end
         ST_WALK: begin
            uw.walk     = 1'b1;
            uw.cond     = JC_WALK_END;
            uw.target_t = ST_SUM;
            uw.target_f = ST_WALK;
         end
         ST_SUM: begin
            uw.cond     = JC_ALWAYS;
            uw.target_t = ST_DONE;
            uw.target_f = ST_DONE;
         end
         ST_DONE: begin
            uw.rsp_load = 1'b1;
            uw.cond     = JC_RSP_FREE;
            uw.target_t = ST_IDLE;
            uw.target_f = ST_DONE;
         end
         default: begin
            uw.cond     = JC_ALWAYS;
            uw.target_t = ST_IDLE;
            uw.target_f = ST_IDLE;
         end
      endcase
      return uw;
   endfunction

   // ones in one byte
   function automatic logic [3:0] pop8(input logic [7:0] b);
      logic [3:0] n;
      n = 4'd0;
      for (int i = 0; i < 8; i++) begin
         n = n + {3'd0, b[i]};
      end
      return n;
   endfunction

endpackage

/* design/brng_req_if.sv */
// command channel of the bitmap range engine
interface brng_req_if
   import brng_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [FUNC_W-1:0]  func;
   logic [INDEX_W-1:0] bit_index;
   logic [INDEX_W-1:0] range_high;
   logic               bit_value;

   modport source (output valid, output func, output bit_index, output range_high,
                   output bit_value, input ready);
   modport sink   (input valid, input func, input bit_index, input range_high,
                   input bit_value, output ready);
endinterface

/* design/brng_rsp_if.sv */
// result channel of the bitmap range engine
interface brng_rsp_if
   import brng_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [POS_W-1:0] value;
   logic             ok;

   modport source (output valid, output value, output ok, input ready);
   modport sink   (input valid, input value, input ok, output ready);
endinterface

/* design/bitmap_range_engine.sv */
// bitmap range engine: top level with the word datapath and channel handling
//
// A bit vector of BIT_CAPACITY bits kept in a memory of 64-bit words and run by
// a small microprogram. One command is taken at a time. After reset a clearing
// pass writes zero to every word, one word a cycle, during which no command is
// taken; csr writes are taken at all times. A command then walks W words
// between its accepting edge and its result, where W is the number of words it
// touches: 1 for put and get, the words spanned by lo..hi for a range command,
// ceil(length/64) for count, and 0 for a rejected command or a count at length
// zero. The word loop reads one word and writes it back in the same cycle
// through the single read and single write port of the memory, so W is the
// walk of the stored words. The result sits in an output register, and the next
// command can be taken while it waits; a new result is only loaded once the old
// one is gone.

module bitmap_range_engine
   import brng_pkg::*;
   #(
      parameter int BIT_CAPACITY = DEFAULT_BIT_CAPACITY
   ) (
      input  logic             clock,
      input  logic             reset,
      input  logic             csr_wr_en,
      input  logic [POS_W-1:0] csr_wr_data,
      brng_req_if.sink         req_bus,
      brng_rsp_if.source       rsp_bus
   );

`include "assert_macros.svh"

   localparam int WORDS  = (BIT_CAPACITY + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;

   // sequencer control and status
   uword_type      ctrl;
   seq_status_type status;
   logic           accept;

   // length register
   logic [POS_W-1:0] bits_in_use_ff;
   logic [POS_W-1:0] len;

   // command decode at the accepting edge
   logic             is_putget, is_range, is_count;
   logic             cmd_ok, cmd_walk, cmd_cnt;
   logic [POS_W-1:0] lo_pos, hi_pos;
   wr_kind_type      cmd_kind;

   // command registers
   logic [POS_W-1:0]  lo_ff, hi_ff;
   logic [ADDR_W-1:0] start_ff, end_ff, addr_ff, addr_in;
   logic              ok_ff, has_work_ff, cnt_en_ff;
   wr_kind_type       wr_kind_ff;

   // word datapath
   logic [WORD_BITS-1:0] rd_word, lower, upper, mask, new_word, masked;
   logic [WORD_BITS-1:0] wr_data;
   logic                 wr_en;
   logic [ADDR_W-1:0]    rd_addr;
   logic [3:0]           bcnt_ff [WORD_BYTES];
   logic [3:0]           bcnt_in [WORD_BYTES];
   logic [POS_W-1:0]     acc_ff, acc_in, bsum;

   // result register
   logic             rsp_valid_ff;
   logic [POS_W-1:0] rsp_value_ff;
   logic             rsp_ok_ff;
   logic             rsp_free, rsp_load_en;

   brng_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   brng_store #(
      .WORDS  (WORDS),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   // csr: length in use, taken as written
   always_ff @(posedge clock) begin
      if (reset) begin
         bits_in_use_ff <= BITS_IN_USE_RESET;
      end else if (csr_wr_en) begin
         bits_in_use_ff <= csr_wr_data;
      end
   end

   // a length above capacity acts as the capacity
   always_comb begin
      if (32'(bits_in_use_ff) > 32'(BIT_CAPACITY)) begin
         len = POS_W'(BIT_CAPACITY);
      end else begin
         len = bits_in_use_ff;
      end
   end

   assign req_bus.ready = ctrl.req_ready;
   assign accept        = req_bus.valid && ctrl.req_ready;

   // decode: check the arguments and turn every command into a word walk lo..hi
   always_comb begin
      is_putget = (req_bus.func == FUNC_PUT) || (req_bus.func == FUNC_GET);
      is_range  = (req_bus.func == FUNC_SET) || (req_bus.func == FUNC_CLEAR) ||
                  (req_bus.func == FUNC_INVERT);
      is_count  = (req_bus.func == FUNC_COUNT);

      cmd_ok = 1'b0;
      if (is_putget) begin
         cmd_ok = {1'b0, req_bus.bit_index} < len;
      end else if (is_range) begin
         cmd_ok = ({1'b0, req_bus.range_high} < len) &&
                  (req_bus.bit_index <= req_bus.range_high);
      end else if (is_count) begin
         cmd_ok = 1'b1;
      end

      // empty vector: count answers zero without a walk
      cmd_walk = cmd_ok && !(is_count && (len == '0));
      // old bit for put and get and the ones count both come from the popcount
      cmd_cnt  = is_putget || is_count;

      lo_pos = is_count ? '0 : {1'b0, req_bus.bit_index};
      if (is_count) begin
         hi_pos = len - POS_W'(1);
      end else if (is_range) begin
         hi_pos = {1'b0, req_bus.range_high};
      end else begin
         hi_pos = {1'b0, req_bus.bit_index};
      end

      priority if (req_bus.func == FUNC_PUT) begin
         cmd_kind = req_bus.bit_value ? WK_OR : WK_ANDN;
      end else if (req_bus.func == FUNC_SET) begin
         cmd_kind = WK_OR;
      end else if (req_bus.func == FUNC_CLEAR) begin
         cmd_kind = WK_ANDN;
      end else if (req_bus.func == FUNC_INVERT) begin
         cmd_kind = WK_XOR;
      end else begin
         cmd_kind = WK_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ok_ff       <= 1'b0;
         has_work_ff <= 1'b0;
         cnt_en_ff   <= 1'b0;
         wr_kind_ff  <= WK_NONE;
      end else if (accept) begin
         ok_ff       <= cmd_ok;
         has_work_ff <= cmd_walk;
         cnt_en_ff   <= cmd_cnt;
         wr_kind_ff  <= cmd_kind;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         lo_ff    <= lo_pos;
         hi_ff    <= hi_pos;
         start_ff <= ADDR_W'(lo_pos[POS_W-1:WORD_SHIFT]);
         end_ff   <= ADDR_W'(hi_pos[POS_W-1:WORD_SHIFT]);
      end
   end

   // word pointer: clearing sweep after reset, then the walk of one command
   always_comb begin
      addr_in = addr_ff;
      if (ctrl.clr_wr || ctrl.walk) begin
         addr_in = addr_ff + ADDR_W'(1);
      end else if (accept) begin
         addr_in = ADDR_W'(lo_pos[POS_W-1:WORD_SHIFT]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= '0;
      end else begin
         addr_ff <= addr_in;
      end
   end

   // the check step fetches the first word, each walk step fetches the next
   assign rd_addr = ctrl.walk ? (addr_ff + ADDR_W'(1)) : addr_ff;

   // edge masks: partial first and last word, whole words between
   always_comb begin
      lower = (addr_ff == start_ff) ? ({WORD_BITS{1'b1}} << lo_ff[WORD_SHIFT-1:0])
                                    : {WORD_BITS{1'b1}};
      upper = (addr_ff == end_ff)
            ? ({WORD_BITS{1'b1}} >> (WORD_SHIFT'(WORD_BITS - 1) - hi_ff[WORD_SHIFT-1:0]))
            : {WORD_BITS{1'b1}};
      mask   = lower & upper;
      masked = rd_word & mask;

      unique case (wr_kind_ff)
         WK_OR:   new_word = rd_word | mask;
         WK_ANDN: new_word = rd_word & ~mask;
         WK_XOR:  new_word = rd_word ^ mask;
         default: new_word = rd_word;
      endcase
   end

   // read-modify-write in one step, zero fill during the clearing sweep
   assign wr_en   = ctrl.clr_wr || (ctrl.walk && (wr_kind_ff != WK_NONE));
   assign wr_data = ctrl.clr_wr ? '0 : new_word;

   // popcount: byte counts registered, folded into the total in the next cycle
   always_comb begin
      for (int k = 0; k < WORD_BYTES; k++) begin
         bcnt_in[k] = (ctrl.walk && cnt_en_ff) ? pop8(masked[8*k +: 8]) : 4'd0;
      end
      bsum = '0;
      for (int k = 0; k < WORD_BYTES; k++) begin
         bsum = bsum + POS_W'(bcnt_ff[k]);
      end
      acc_in = accept ? '0 : (acc_ff + bsum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < WORD_BYTES; k++) begin
            bcnt_ff[k] <= 4'd0;
         end
         acc_ff <= '0;
      end else begin
         for (int k = 0; k < WORD_BYTES; k++) begin
            bcnt_ff[k] <= bcnt_in[k];
         end
         acc_ff <= acc_in;
      end
   end

   // result register: loaded only when the previous beat has left
   assign rsp_free    = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_load_en = ctrl.rsp_load && rsp_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load_en) begin
         rsp_value_ff <= acc_ff;
         rsp_ok_ff    <= ok_ff;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.value = rsp_value_ff;
   assign rsp_bus.ok    = rsp_ok_ff;

   // status back to the sequencer
   always_comb begin
      status.accept    = accept;
      status.has_work  = has_work_ff;
      status.walk_end  = (addr_ff == end_ff);
      status.clear_end = (addr_ff == ADDR_W'(WORDS - 1));
      status.rsp_free  = rsp_free;
   end

   // one command at a time: an accepted beat closes the input for the next cycle
   `BRNG_ASSERT_NEXT(a_one_cmd, clock, reset, accept, !req_bus.ready, "second beat taken early")
   // a waiting result is never overwritten
   `BRNG_ASSERT_IMPLY(a_rsp_hold, clock, reset, ctrl.rsp_load && rsp_valid_ff && !rsp_bus.ready, !rsp_load_en, "pending result overwritten")
   // the walk stays inside the words of its range
   `BRNG_ASSERT_IMPLY(a_walk_bounds, clock, reset, ctrl.walk, (addr_ff >= start_ff) && (addr_ff <= end_ff), "walk left its range")
   // a rejected command reports zero
   `BRNG_ASSERT_IMPLY(a_reject_zero, clock, reset, rsp_bus.valid && !rsp_bus.ok, rsp_bus.value == '0, "rejected beat with nonzero value")

endmodule

/* design/brng_store.sv */
// word memory holding the bit vector, one write and one registered read port
module brng_store
   import brng_pkg::*;
   #(
      parameter int WORDS  = DEFAULT_WORDS,
      parameter int ADDR_W = DEFAULT_ADDR_W
   ) (
      input  logic                 clock,
      input  logic                 wr_en,
      input  logic [ADDR_W-1:0]    wr_addr,
      input  logic [WORD_BITS-1:0] wr_data,
      input  logic [ADDR_W-1:0]    rd_addr,
      output logic [WORD_BITS-1:0] rd_data
   );

   logic [WORD_BITS-1:0] mem [WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/brng_seq.sv */
// microprogram sequencer: step counter, control store and conditional jumps
module brng_seq
   import brng_pkg::*;
   (
      input  logic           clock,
      input  logic           reset,
      input  seq_status_type status,
      output uword_type      ctrl
   );

   step_type upc_ff;
   step_type upc_in;
   logic     taken;

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= ST_CLEAR;
      end else begin
         upc_ff <= upc_in;
      end
   end

   always_comb begin
      ctrl = brng_rom(upc_ff);
      unique case (ctrl.cond)
         JC_ALWAYS:    taken = 1'b1;
         JC_CLEAR_END: taken = status.clear_end;
         JC_ACCEPT:    taken = status.accept;
         JC_HAS_WORK:  taken = status.has_work;
         JC_WALK_END:  taken = status.walk_end;
         JC_RSP_FREE:  taken = status.rsp_free;
         default:      taken = 1'b0;
      endcase
      upc_in = taken ? ctrl.target_t : ctrl.target_f;
   end

endmodule
